// File: rtl/acgc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acgc_pkg
// Shared types and constants for the compressor gain control core.
// ----------------------------------------------------------------------------
package acgc_pkg;

    localparam int NUM_W = 38;
    localparam int DEN_W = 24;

    localparam logic signed [15:0] LEVEL_FLOOR   = -16'sd23040;
    localparam logic signed [20:0] LOG_OFFSET    = 21'sd786432;
    localparam logic signed [40:0] DB_PER_OCTAVE = 41'sd394566;
    localparam logic signed [40:0] ROUND_HALF    = 41'sd8388608;
    localparam logic [17:0]        DRIVE_NUM     = 18'd183183;
    localparam logic [9:0]         DRIVE_DEN     = 10'd1000;
    localparam logic [11:0]        DRIVE_MAX     = 12'd4095;
    localparam logic [13:0]        RCNT_MAX      = 14'd16383;
    localparam logic [8:0]         ACNT_MAX      = 9'd511;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_RATIO     = 2'd1;
    localparam logic [1:0] REG_ATTACK    = 2'd2;
    localparam logic [1:0] REG_RELEASE   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOG_INIT,
        ST_LOG_SQ,
        ST_LOG_MUL,
        ST_LEVEL,
        ST_BASE,
        ST_DIV_BASE,
        ST_RAMP,
        ST_DIV_RAMP,
        ST_OUT,
        ST_TICK,
        ST_DIV_CONV,
        ST_STEP
    } state_t;

    typedef struct packed {
        logic load_in;
        logic log_init;
        logic log_step;
        logic log_mul;
        logic level_upd;
        logic base_start;
        logic zero_v;
        logic base_take;
        logic ramp_start;
        logic ramp_skip;
        logic ramp_take;
        logic conv_start;
        logic conv_take;
        logic tick_step;
        logic out_load;
    } acgc_cmd_t;

    typedef struct packed {
        logic ramp_running;
        logic base_go;
        logic ramp_div;
        logic conv_go;
        logic div_busy;
        logic out_free;
    } acgc_sts_t;

endpackage

// File: rtl/audio_compressor_gain_control_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_compressor_gain_control_core
// Sample level detector and compressor gain drive with attack/release ramps.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction per ADC sample (s_tuser = 0) or ramp tick
//   (s_tuser = 1). Samples give one m_ transaction with the 12-bit drive
//   code; ticks give none.
//   cfg_ channel: register writes (threshold, ratio, attack and release
//   steps), always ready; write only while the core is idle.
//   A sample runs the 16 log squaring steps and, for a nonzero drive, a
//   division on the shared divider; a drive that is scaled by a ramp takes
//   a second division there. A zero drive skips both divisions. A tick
//   only returns to idle while the ramps are stopped, applies a ramp step
//   while a ramp runs, and first converts the ramp through the divider
//   when a conversion is needed. One transaction is processed at a time;
//   s_tready is high only when idle, so the next transaction is taken in
//   the cycle after the previous one is done.
//   The result sits in an output register, so a new transaction is taken
//   while it waits; a stalled receiver only blocks the next result.
//   Reset (aresetn low, synchronous) restores default registers, stops the
//   ramps and drops any pending result.
// ----------------------------------------------------------------------------
module audio_compressor_gain_control_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] drive_value
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    acgc_pkg::acgc_cmd_t cmd;
    acgc_pkg::acgc_sts_t sts;

    assign cfg_ready = 1'b1;

    acgc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    acgc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: rtl/acgc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acgc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acgc_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [acgc_pkg::NUM_W-1:0] num,
    input  logic [acgc_pkg::DEN_W-1:0] den,
    output logic                       busy,
    output logic [acgc_pkg::NUM_W-1:0] quot
);

    logic [acgc_pkg::NUM_W-1:0] qr_reg, qr_next;
    logic [acgc_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [acgc_pkg::DEN_W-1:0] den_reg, den_next;
    logic [5:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [acgc_pkg::DEN_W:0]   shifted;
    logic [acgc_pkg::DEN_W:0]   diff;
    logic                       ge;

    always_comb begin
        shifted   = {rem_reg, qr_reg[acgc_pkg::NUM_W-1]};
        ge        = shifted >= {1'b0, den_reg};
        diff      = shifted - {1'b0, den_reg};
        qr_next   = qr_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            qr_next   = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = 6'(acgc_pkg::NUM_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[acgc_pkg::DEN_W-1:0] : shifted[acgc_pkg::DEN_W-1:0];
            qr_next  = {qr_reg[acgc_pkg::NUM_W-2:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        qr_reg  <= qr_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quot = qr_reg;

endmodule

// File: rtl/acgc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acgc_ctrl
// Sequencer for sample and tick transactions.
// ----------------------------------------------------------------------------
module acgc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tuser,
    output logic                s_tready,
    input  acgc_pkg::acgc_sts_t sts,
    output acgc_pkg::acgc_cmd_t cmd
);

    acgc_pkg::state_t state_reg, state_next;
    logic [3:0]       step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            acgc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = s_tuser ? acgc_pkg::ST_TICK : acgc_pkg::ST_LOG_INIT;
                end
            end
            acgc_pkg::ST_LOG_INIT: begin
                step_next  = '0;
                state_next = acgc_pkg::ST_LOG_SQ;
            end
            acgc_pkg::ST_LOG_SQ: begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15) begin
                    state_next = acgc_pkg::ST_LOG_MUL;
                end
            end
            acgc_pkg::ST_LOG_MUL: state_next = acgc_pkg::ST_LEVEL;
            acgc_pkg::ST_LEVEL:   state_next = acgc_pkg::ST_BASE;
            acgc_pkg::ST_BASE: begin
                state_next = sts.base_go ? acgc_pkg::ST_DIV_BASE : acgc_pkg::ST_OUT;
            end
            acgc_pkg::ST_DIV_BASE: begin
                if (!sts.div_busy) begin
                    state_next = acgc_pkg::ST_RAMP;
                end
            end
            acgc_pkg::ST_RAMP: begin
                state_next = sts.ramp_div ? acgc_pkg::ST_DIV_RAMP : acgc_pkg::ST_OUT;
            end
            acgc_pkg::ST_DIV_RAMP: begin
                if (!sts.div_busy) begin
                    state_next = acgc_pkg::ST_OUT;
                end
            end
            acgc_pkg::ST_OUT: begin
                if (sts.out_free) begin
                    state_next = acgc_pkg::ST_IDLE;
                end
            end
            acgc_pkg::ST_TICK: begin
                if (!sts.ramp_running) begin
                    state_next = acgc_pkg::ST_IDLE;
                end else if (sts.conv_go) begin
                    state_next = acgc_pkg::ST_DIV_CONV;
                end else begin
                    state_next = acgc_pkg::ST_STEP;
                end
            end
            acgc_pkg::ST_DIV_CONV: begin
                if (!sts.div_busy) begin
                    state_next = acgc_pkg::ST_STEP;
                end
            end
            acgc_pkg::ST_STEP: state_next = acgc_pkg::ST_IDLE;
            default:           state_next = acgc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            acgc_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            acgc_pkg::ST_LOG_INIT: cmd.log_init  = 1'b1;
            acgc_pkg::ST_LOG_SQ:   cmd.log_step  = 1'b1;
            acgc_pkg::ST_LOG_MUL:  cmd.log_mul   = 1'b1;
            acgc_pkg::ST_LEVEL:    cmd.level_upd = 1'b1;
            acgc_pkg::ST_BASE: begin
                cmd.base_start = sts.base_go;
                cmd.zero_v     = !sts.base_go;
            end
            acgc_pkg::ST_DIV_BASE: cmd.base_take = !sts.div_busy;
            acgc_pkg::ST_RAMP: begin
                cmd.ramp_start = sts.ramp_div;
                cmd.ramp_skip  = !sts.ramp_div;
            end
            acgc_pkg::ST_DIV_RAMP: cmd.ramp_take = !sts.div_busy;
            acgc_pkg::ST_OUT:      cmd.out_load  = sts.out_free;
            acgc_pkg::ST_TICK:     cmd.conv_start = sts.ramp_running && sts.conv_go;
            acgc_pkg::ST_DIV_CONV: cmd.conv_take = !sts.div_busy;
            acgc_pkg::ST_STEP:     cmd.tick_step = 1'b1;
            default:               cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= acgc_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: rtl/acgc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acgc_dp
// Datapath: config registers, level log, ramp state, divider, output register.
// ----------------------------------------------------------------------------
module acgc_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         s_tdata,
    input  logic                s_tuser,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [15:0]         m_tdata,
    input  acgc_pkg::acgc_cmd_t cmd,
    output acgc_pkg::acgc_sts_t sts
);

    logic signed [15:0] thr_reg;
    logic [13:0]        ratio_reg;
    logic [8:0]         asteps_reg;
    logic [13:0]        rsteps_reg;
    logic               comp_reg, comp_next;
    logic               att_reg, att_next;
    logic               rel_reg, rel_next;
    logic               run_reg, run_next;
    logic [8:0]         ac_reg, ac_next;
    logic [13:0]        rc_reg, rc_next;
    logic signed [15:0] level_reg, level_next;
    logic               mvalid_reg;
    logic [11:0]        drive_reg;

    logic               action_reg;
    logic [11:0]        sample_reg;
    logic [3:0]         n_reg;
    logic [30:0]        m_reg;
    logic [15:0]        frac_reg;
    logic signed [40:0] prod_reg;
    logic [23:0]        v_reg;

    logic [13:0]        ratio_eff, rs_eff;
    logic [8:0]         as_eff;
    logic [13:0]        x;
    logic [3:0]         msb;
    logic [61:0]        sq;
    logic [31:0]        t;
    logic signed [20:0] ldiff;
    logic signed [40:0] prod_next;
    logic signed [40:0] rounded;
    logic signed [16:0] diff;
    logic [13:0]        rgap;
    logic               start;
    logic [acgc_pkg::NUM_W-1:0] num;
    logic [acgc_pkg::DEN_W-1:0] den;
    logic               busy;
    logic [acgc_pkg::NUM_W-1:0] quot;

    assign ratio_eff = (ratio_reg == '0) ? 14'd1 : ratio_reg;
    assign as_eff    = (asteps_reg == '0) ? 9'd1 : asteps_reg;
    assign rs_eff    = (rsteps_reg == '0) ? 14'd1 : rsteps_reg;

    always_comb begin
        x   = {2'b00, sample_reg} + {1'b0, sample_reg, 1'b0};
        msb = '0;
        for (int i = 0; i < 14; i++) begin
            if (x[i]) begin
                msb = 4'(i);
            end
        end
        sq        = 62'(m_reg) * 62'(m_reg);
        t         = sq[61:30];
        ldiff     = $signed({1'b0, n_reg, frac_reg}) - acgc_pkg::LOG_OFFSET;
        prod_next = 41'(ldiff) * acgc_pkg::DB_PER_OCTAVE;
        rounded   = (prod_reg + acgc_pkg::ROUND_HALF) >>> 24;
        diff      = 17'(level_reg) - 17'(thr_reg);
        rgap      = rs_eff - rc_reg;
    end

    always_comb begin
        level_next = (sample_reg == '0) ? acgc_pkg::LEVEL_FLOOR : rounded[15:0];
        start      = cmd.base_start || cmd.ramp_start || cmd.conv_start;
        num        = '0;
        den        = 24'd1;
        if (cmd.base_start) begin
            num = 38'(diff[15:0]) * 38'(acgc_pkg::DRIVE_NUM);
            den = 24'(ratio_eff) * 24'(acgc_pkg::DRIVE_DEN);
        end else if (cmd.ramp_start) begin
            num = att_reg ? 38'(v_reg) * 38'(ac_reg) : 38'(v_reg) * 38'(rgap);
            den = att_reg ? 24'(as_eff) : 24'(rs_eff);
        end else if (cmd.conv_start) begin
            num = att_reg ? 38'(ac_reg) * 38'(rs_eff) : 38'(rc_reg) * 38'(as_eff);
            den = att_reg ? 24'(as_eff) : 24'(rs_eff);
        end
    end

    acgc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .num     (num),
        .den     (den),
        .busy    (busy),
        .quot    (quot)
    );

    always_comb begin
        comp_next = comp_reg;
        att_next  = att_reg;
        rel_next  = rel_reg;
        run_next  = run_reg;
        ac_next   = ac_reg;
        rc_next   = rc_reg;
        if (cmd.level_upd) begin
            if (level_next >= thr_reg && !comp_reg) begin
                comp_next = 1'b1;
                att_next  = 1'b1;
                run_next  = 1'b1;
            end else if (level_next <= thr_reg && comp_reg && !att_reg) begin
                rel_next = 1'b1;
                run_next = 1'b1;
            end
        end
        if (cmd.conv_take) begin
            if (att_reg) begin
                rc_next  = (quot > 38'(acgc_pkg::RCNT_MAX)) ? acgc_pkg::RCNT_MAX : quot[13:0];
                ac_next  = 9'd1;
                att_next = 1'b0;
                rel_next = 1'b1;
            end else begin
                ac_next  = (quot > 38'(acgc_pkg::ACNT_MAX)) ? acgc_pkg::ACNT_MAX : quot[8:0];
                rc_next  = 14'd1;
                rel_next = 1'b0;
                att_next = 1'b1;
            end
        end
        if (cmd.tick_step) begin
            if (att_reg) begin
                if (ac_reg >= as_eff) begin
                    run_next = 1'b0;
                    att_next = 1'b0;
                    ac_next  = 9'd1;
                end else begin
                    ac_next = ac_reg + 9'd1;
                end
            end
            if (rel_reg) begin
                if (rc_reg >= rs_eff) begin
                    run_next  = 1'b0;
                    comp_next = 1'b0;
                    rel_next  = 1'b0;
                    rc_next   = 14'd1;
                end else begin
                    rc_next = rc_reg + 14'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= -16'sd5120;
            ratio_reg  <= 14'd1024;
            asteps_reg <= 9'd10;
            rsteps_reg <= 14'd1000;
            comp_reg   <= 1'b0;
            att_reg    <= 1'b0;
            rel_reg    <= 1'b0;
            run_reg    <= 1'b0;
            ac_reg     <= 9'd1;
            rc_reg     <= 14'd1;
            level_reg  <= acgc_pkg::LEVEL_FLOOR;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    acgc_pkg::REG_THRESHOLD: thr_reg    <= $signed(cfg_data);
                    acgc_pkg::REG_RATIO:     ratio_reg  <= cfg_data[13:0];
                    acgc_pkg::REG_ATTACK:    asteps_reg <= cfg_data[8:0];
                    acgc_pkg::REG_RELEASE:   rsteps_reg <= cfg_data[13:0];
                    default:                 thr_reg    <= thr_reg;
                endcase
            end
            comp_reg <= comp_next;
            att_reg  <= att_next;
            rel_reg  <= rel_next;
            run_reg  <= run_next;
            ac_reg   <= ac_next;
            rc_reg   <= rc_next;
            if (cmd.level_upd) begin
                level_reg <= level_next;
            end
            if (cmd.out_load) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            action_reg <= s_tuser;
            sample_reg <= s_tdata[11:0];
        end
        if (cmd.log_init) begin
            n_reg    <= msb;
            m_reg    <= 31'(x) << (5'd30 - {1'b0, msb});
            frac_reg <= '0;
        end
        if (cmd.log_step) begin
            m_reg    <= t[31] ? t[31:1] : t[30:0];
            frac_reg <= {frac_reg[14:0], t[31]};
        end
        if (cmd.log_mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.zero_v) begin
            v_reg <= '0;
        end
        if (cmd.base_take || cmd.ramp_take) begin
            v_reg <= quot[23:0];
        end
        if (cmd.ramp_skip && rel_reg) begin
            v_reg <= '0;
        end
        if (cmd.out_load) begin
            drive_reg <= (v_reg > 24'(acgc_pkg::DRIVE_MAX)) ? acgc_pkg::DRIVE_MAX : v_reg[11:0];
        end
    end

    always_comb begin
        sts.ramp_running = run_reg && action_reg;
        sts.base_go      = comp_reg && (diff > 17'sd0);
        sts.ramp_div     = att_reg || (rel_reg && (rc_reg < rs_eff));
        sts.conv_go      = (att_reg && (level_reg < thr_reg))
                        || (rel_reg && (level_reg > thr_reg));
        sts.div_busy     = busy;
        sts.out_free     = !mvalid_reg || m_tready;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {4'b0000, drive_reg};

endmodule

// File: dv/tb_audio_compressor_gain_control_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_compressor_gain_control_core
// Drives ADC samples and ramp ticks through the compressor core and
// compares every drive code against a cycle-free model of the level
// detector, the attack/release ramps and the drive scaling. The register
// settings change between phases, and both sides of the stream stall at
// random.
// ----------------------------------------------------------------------------
module tb_audio_compressor_gain_control_core;

    typedef struct packed {
        logic        action;
        logic [11:0] sample;
    } item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    item_t       pending_items[$];
    logic [11:0] drive_expected[$];
    int          errors = 0;
    bit          no_gaps = 0;
    bit          rx_hold_req = 0;
    int          rx_hold_cnt = 0;

    // model registers and state
    logic signed [15:0] thr_db;
    int unsigned        ratio, asteps, rsteps;
    bit                 comp_on, atk_on, rel_on, ramp_on;
    int unsigned        atk_cnt, rel_cnt;
    logic signed [15:0] prev_level;

    always #5 aclk = ~aclk;

    audio_compressor_gain_control_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    function automatic logic signed [15:0] sample_level(input logic [11:0] s);
        longint unsigned x, m, frac, n;
        longint p, u;
        if (s == 0) return acgc_pkg::LEVEL_FLOOR;
        x = 3 * longint'(s);
        n = 0;
        while ((x >> (n + 1)) != 0) n++;
        m = x << (30 - n);
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        p = (longint'(n * 65536 + frac) - 786432) * 394566;
        u = p + (longint'(32768) << 24) + (longint'(1) << 23);
        return 16'(longint'(longint'(unsigned'(u) >> 24) - 32768));
    endfunction

    function automatic int unsigned nz(input int unsigned v);
        return v == 0 ? 1 : v;
    endfunction

    task automatic model_reset();
        thr_db = -16'sd5120; ratio = 1024; asteps = 10; rsteps = 1000;
        comp_on = 0; atk_on = 0; rel_on = 0; ramp_on = 0;
        atk_cnt = 1; rel_cnt = 1; prev_level = acgc_pkg::LEVEL_FLOOR;
    endtask

    task automatic compress_step(input item_t it);
        int unsigned as, rs, c;
        longint unsigned v;
        longint diff;
        as = nz(asteps);
        rs = nz(rsteps);
        if (it.action) begin
            if (!ramp_on) return;
            if (atk_on && prev_level < thr_db) begin
                atk_on = 0; rel_on = 1;
                v = longint'(atk_cnt) * rs / as;
                rel_cnt = v > acgc_pkg::RCNT_MAX ? acgc_pkg::RCNT_MAX : int'(v);
                atk_cnt = 1;
            end
            if (rel_on && prev_level > thr_db) begin
                rel_on = 0; atk_on = 1;
                v = longint'(rel_cnt) * as / rs;
                atk_cnt = v > acgc_pkg::ACNT_MAX ? acgc_pkg::ACNT_MAX : int'(v);
                rel_cnt = 1;
            end
            if (atk_on) begin
                c = atk_cnt + 1;
                if (c - 1 >= as) begin
                    ramp_on = 0; atk_on = 0; atk_cnt = 1;
                end else atk_cnt = c;
            end
            if (rel_on) begin
                c = rel_cnt + 1;
                if (c - 1 >= rs) begin
                    ramp_on = 0; comp_on = 0; rel_on = 0; rel_cnt = 1;
                end else rel_cnt = c;
            end
            return;
        end
        prev_level = sample_level(it.sample);
        if (prev_level >= thr_db && !comp_on) begin
            comp_on = 1; atk_on = 1; ramp_on = 1;
        end else if (prev_level <= thr_db && comp_on && !atk_on) begin
            rel_on = 1; ramp_on = 1;
        end
        v = 0;
        if (comp_on) begin
            diff = longint'(prev_level) - longint'(thr_db);
            if (diff > 0) v = longint'(diff) * 183183 / (1000 * longint'(nz(ratio)));
            if (atk_on) v = v * atk_cnt / as;
            if (rel_on) v = rel_cnt >= rs ? 0 : v * (rs - rel_cnt) / rs;
            if (v > acgc_pkg::DRIVE_MAX) v = acgc_pkg::DRIVE_MAX;
        end
        drive_expected.push_back(12'(v));
    endtask

    // driver
    always @(posedge aclk) begin
        item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                it.action = s_tuser;
                it.sample = s_tdata[11:0];
                compress_step(it);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && (no_gaps || $urandom_range(99) >= 35)) begin
                    it = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'b0, it.sample};
                    s_tuser <= it.action;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        logic [11:0] want;
        if (m_tvalid && m_tready) begin
            if (drive_expected.size() == 0) begin
                $display("%0t: unexpected drive transaction, actual %0d", $time, m_tdata[11:0]);
                errors++;
            end else begin
                want = drive_expected.pop_front();
                if (m_tdata[11:0] !== want) begin
                    $display("%0t: drive_value mismatch, expected %0d actual %0d",
                             $time, want, m_tdata[11:0]);
                    errors++;
                end
                if (m_tdata[15:12] !== 4'b0) begin
                    $display("%0t: tdata pad mismatch, expected 0 actual %0h",
                             $time, m_tdata[15:12]);
                    errors++;
                end
            end
        end
        if (rx_hold_req && rx_hold_cnt < 600) begin
            rx_hold_cnt++;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_gaps || $urandom_range(99) >= 35;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            acgc_pkg::REG_THRESHOLD: thr_db = val;
            acgc_pkg::REG_RATIO:     ratio = val[13:0];
            acgc_pkg::REG_ATTACK:    asteps = val[8:0];
            acgc_pkg::REG_RELEASE:   rsteps = val[13:0];
            default: ;
        endcase
    endtask

    task automatic add_item(input bit act, input int unsigned s);
        item_t it;
        it.action = act;
        it.sample = 12'(s);
        pending_items.push_back(it);
    endtask

    task automatic add_ticks(input int n);
        repeat (n) add_item(1'b1, $urandom_range(4095));
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || drive_expected.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic random_phase(input int budget);
        int r;
        while (budget > 0) begin
            r = $urandom_range(9);
            if (r < 7) begin
                repeat ($urandom_range(1, 3)) add_item(1'b0, $urandom_range(1024, 4095));
                add_ticks($urandom_range(0, 30));
                repeat ($urandom_range(1, 3)) add_item(1'b0, $urandom_range(0, 200));
                add_ticks($urandom_range(0, 30));
                budget -= 20;
            end else begin
                add_item(1'($urandom_range(1)), $urandom_range(4095));
                budget--;
            end
        end
    endtask

    initial begin
        model_reset();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: idle ticks, field extremes, attack into release
        add_ticks(2);
        add_item(1'b0, 0);
        add_item(1'b0, 1);
        add_item(1'b0, 4095);
        add_ticks(3);
        add_item(1'b0, 2048);
        add_item(1'b0, 10);
        add_ticks(4);
        add_item(1'b0, 4095);
        add_ticks(12);
        add_item(1'b0, 0);
        add_ticks(3);
        add_item(1'b0, 3000);
        add_ticks(2);
        drain();

        write_reg(acgc_pkg::REG_THRESHOLD, -16'sd23040);
        write_reg(acgc_pkg::REG_RATIO, 16'd256);
        write_reg(acgc_pkg::REG_ATTACK, 16'd1);
        write_reg(acgc_pkg::REG_RELEASE, 16'd1000);
        no_gaps = 1;
        random_phase(40);
        drain();
        no_gaps = 0;

        // release ramp run to its end
        write_reg(acgc_pkg::REG_THRESHOLD, -16'sd5120);
        add_item(1'b0, 4095);
        add_ticks(12);
        add_item(1'b0, 5);
        add_ticks(1005);
        add_item(1'b0, 4000);
        drain();

        write_reg(acgc_pkg::REG_THRESHOLD, 16'sd2560);
        write_reg(acgc_pkg::REG_RATIO, 16'd8192);
        write_reg(acgc_pkg::REG_ATTACK, 16'd300);
        write_reg(acgc_pkg::REG_RELEASE, 16'd12000);
        random_phase(20);
        drain();

        // zero step counts and ratio fall back to one
        write_reg(acgc_pkg::REG_THRESHOLD, -16'sd4000);
        write_reg(acgc_pkg::REG_RATIO, 16'd0);
        write_reg(acgc_pkg::REG_ATTACK, 16'd0);
        write_reg(acgc_pkg::REG_RELEASE, 16'd0);
        random_phase(20);
        drain();

        write_reg(acgc_pkg::REG_THRESHOLD, -16'sd3000);
        write_reg(acgc_pkg::REG_RATIO, 16'd300);
        write_reg(acgc_pkg::REG_ATTACK, 16'd511);
        write_reg(acgc_pkg::REG_RELEASE, 16'd16383);
        random_phase(20);
        drain();

        // receiver held off while samples keep coming
        write_reg(acgc_pkg::REG_THRESHOLD, -16'sd8000);
        write_reg(acgc_pkg::REG_RATIO, 16'd512);
        write_reg(acgc_pkg::REG_ATTACK, 16'd20);
        write_reg(acgc_pkg::REG_RELEASE, 16'd1000);
        rx_hold_req = 1;
        repeat (20) add_item(1'b0, $urandom_range(4095));
        random_phase(30);
        drain();

        if (errors == 0) begin
            $display("audio_compressor_gain_control_core test passed");
        end else begin
            $display("audio_compressor_gain_control_core test failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("audio_compressor_gain_control_core test failed");
        $finish;
    end
endmodule

// File: files.f
rtl/acgc_pkg.sv
rtl/acgc_div.sv
rtl/acgc_ctrl.sv
rtl/acgc_dp.sv
rtl/audio_compressor_gain_control_core.sv
dv/tb_audio_compressor_gain_control_core.sv
